>>> hdl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  // fixed field widths of the pixel channels
  localparam int HUE_W  = 15;
  localparam int CHAN_W = 8;

  // degrees per sector and per full turn, before hue fraction scaling
  localparam int SECTOR_DEG = 60;
  localparam int TURN_DEG   = 360;

  // odd factor of the sector width (60 = 15 * 4)
  localparam int SECTOR_ODD = 15;

  // largest channel code
  localparam int CHAN_MAX = 255;

  // number of register stages from input transfer to output register
  localparam int PIPE_DEPTH = 7;

  // hue sectors, 60 degrees each
  typedef enum logic [2:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5
  } sector_t;

endpackage

>>> hdl/hsv2rgb_split.sv
module hsv2rgb_split #(
  parameter int FRACTION_BITS     = 16,
  parameter int HUE_FRACTION_BITS = 6,
  parameter int SW                = FRACTION_BITS + 1,
  parameter int POS_W             = 12
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]      hue,
  input  logic [SW-1:0]                      sat,
  input  logic [SW-1:0]                      val,
  output hsv2rgb_pkg::sector_t               sector,
  output logic [POS_W-1:0]                   pos,
  output logic [SW-1:0]                      sat_c,
  output logic [SW-1:0]                      val_o
);
  import hsv2rgb_pkg::*;

  localparam int SECTOR = SECTOR_DEG << HUE_FRACTION_BITS;
  localparam int FULL   = TURN_DEG << HUE_FRACTION_BITS;
  localparam int TURN_W = $clog2(FULL + 1);
  localparam int HX_W   = (TURN_W > HUE_W) ? TURN_W : HUE_W;
  localparam logic [SW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  logic [HX_W-1:0]  hue_x;
  logic [HX_W-1:0]  hue_c;
  logic [HX_W-1:0]  base;
  logic [2:0]       sec_idx;
  sector_t          sector_nxt;
  logic [POS_W-1:0] pos_nxt;
  logic [SW-1:0]    sat_nxt;

  sector_t          sector_r;
  logic [POS_W-1:0] pos_r;
  logic [SW-1:0]    sat_r;
  logic [SW-1:0]    val_r;

  always_comb begin
    hue_x = HX_W'(hue);
    // out-of-range hue wraps to zero
    hue_c = (hue_x >= HX_W'(FULL)) ? '0 : hue_x;
    sec_idx = 3'd0;
    base    = '0;
    // thresholds are independent compares, highest match wins
    for (int k = 1; k < 6; k++) begin
      if (hue_c >= HX_W'(k * SECTOR)) begin
        sec_idx = 3'(k);
        base    = HX_W'(k * SECTOR);
      end
    end
    sector_nxt = sector_t'(sec_idx);
    pos_nxt    = POS_W'(hue_c - base);
    sat_nxt    = (sat > ONE) ? ONE : sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sector_r <= sector_nxt;
      pos_r    <= pos_nxt;
      sat_r    <= sat_nxt;
      val_r    <= val;
    end
  end

  assign sector = sector_r;
  assign pos    = pos_r;
  assign sat_c  = sat_r;
  assign val_o  = val_r;

endmodule

>>> hdl/hsv2rgb_frac.sv
module hsv2rgb_frac #(
  parameter int FRACTION_BITS     = 16,
  parameter int HUE_FRACTION_BITS = 6,
  parameter int SW                = FRACTION_BITS + 1,
  parameter int POS_W             = 12
) (
  input  logic                  clk,
  input  logic [2:0]            en,
  input  hsv2rgb_pkg::sector_t  sector_i,
  input  logic [POS_W-1:0]      pos,
  input  logic [SW-1:0]         sat_i,
  input  logic [SW-1:0]         val_i,
  output hsv2rgb_pkg::sector_t  sector_o,
  output logic [SW-1:0]         sat_o,
  output logic [SW-1:0]         sf_o,
  output logic [SW-1:0]         val_o
);
  import hsv2rgb_pkg::*;

  // sector width is 15 * 2^M2, so divide by 2^M2 then by 15
  localparam int M2          = HUE_FRACTION_BITS + 2;
  localparam int HALF_SECTOR = (SECTOR_DEG << HUE_FRACTION_BITS) / 2;
  localparam int PW          = SW + POS_W;
  localparam int YW          = FRACTION_BITS + 4;
  localparam int KB          = ((YW + 3) / 4) * 4;
  localparam longint RECIP   = ((64'd1 << KB) - 64'd1) / SECTOR_ODD;
  localparam int QW          = YW + KB;

  // stage 2: s * pos
  sector_t       sec2_r;
  logic [PW-1:0] prod2_r;
  logic [SW-1:0] sat2_r;
  logic [SW-1:0] val2_r;
  logic [PW-1:0] prod2_nxt;

  // stage 3: rounded shift and reciprocal estimate of the divide by 15
  sector_t       sec3_r;
  logic [YW-1:0] y3_r;
  logic [SW-1:0] qe3_r;
  logic [SW-1:0] sat3_r;
  logic [SW-1:0] val3_r;
  logic [PW:0]   rsum;
  logic [YW-1:0] y3_nxt;
  logic [QW-1:0] qprod;
  logic [SW-1:0] qe3_nxt;

  // stage 4: one-step correction, clamp to s
  sector_t       sec4_r;
  logic [SW-1:0] sf4_r;
  logic [SW-1:0] sat4_r;
  logic [SW-1:0] val4_r;
  logic [YW-1:0] q15;
  logic [YW-1:0] rem;
  logic [SW:0]   sf_raw;
  logic [SW-1:0] sf4_nxt;

  always_comb begin
    prod2_nxt = PW'(sat_i) * PW'(pos);
  end

  always_comb begin
    rsum    = (PW + 1)'(prod2_r) + (PW + 1)'(HALF_SECTOR);
    y3_nxt  = YW'(rsum >> M2);
    qprod   = QW'(y3_nxt) * QW'(RECIP);
    qe3_nxt = SW'(qprod >> KB);
  end

  always_comb begin
    // estimate is at most one short of the true quotient
    q15     = (YW'(qe3_r) << 4) - YW'(qe3_r);
    rem     = y3_r - q15;
    sf_raw  = (SW + 1)'(qe3_r) + ((rem >= YW'(SECTOR_ODD)) ? (SW + 1)'(1) : '0);
    sf4_nxt = (sf_raw > (SW + 1)'(sat3_r)) ? sat3_r : SW'(sf_raw);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sec2_r  <= sector_i;
      prod2_r <= prod2_nxt;
      sat2_r  <= sat_i;
      val2_r  <= val_i;
    end
    if (en[1]) begin
      sec3_r <= sec2_r;
      y3_r   <= y3_nxt;
      qe3_r  <= qe3_nxt;
      sat3_r <= sat2_r;
      val3_r <= val2_r;
    end
    if (en[2]) begin
      sec4_r <= sec3_r;
      sf4_r  <= sf4_nxt;
      sat4_r <= sat3_r;
      val4_r <= val3_r;
    end
  end

  assign sector_o = sec4_r;
  assign sat_o    = sat4_r;
  assign sf_o     = sf4_r;
  assign val_o    = val4_r;

endmodule

>>> hdl/hsv2rgb_mix.sv
module hsv2rgb_mix #(
  parameter int FRACTION_BITS = 16,
  parameter int SW            = FRACTION_BITS + 1
) (
  input  logic                              clk,
  input  logic [2:0]                        en,
  input  hsv2rgb_pkg::sector_t              sector_i,
  input  logic [SW-1:0]                     sat,
  input  logic [SW-1:0]                     sf,
  input  logic [SW-1:0]                     val,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]    red,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]    green,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]    blue
);
  import hsv2rgb_pkg::*;

  localparam logic [SW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam int VW  = SW + 8;
  localparam int PRW = VW + SW;

  // stage 5: weights and 255 * v
  sector_t       sec5_r;
  logic [SW-1:0] wp5_r;
  logic [SW-1:0] wq5_r;
  logic [SW-1:0] wt5_r;
  logic [VW-1:0] v5_r;
  logic [SW-1:0] wp5_nxt;
  logic [SW-1:0] wq5_nxt;
  logic [SW-1:0] wt5_nxt;
  logic [VW-1:0] v5_nxt;

  // stage 6: products
  sector_t        sec6_r;
  logic [PRW-1:0] pv6_r;
  logic [PRW-1:0] pp6_r;
  logic [PRW-1:0] pq6_r;
  logic [PRW-1:0] pt6_r;

  // stage 7: round, saturate, route
  logic [CHAN_W-1:0] cv;
  logic [CHAN_W-1:0] cp;
  logic [CHAN_W-1:0] cq;
  logic [CHAN_W-1:0] ct;
  logic [CHAN_W-1:0] red_nxt;
  logic [CHAN_W-1:0] green_nxt;
  logic [CHAN_W-1:0] blue_nxt;
  logic [CHAN_W-1:0] red_r;
  logic [CHAN_W-1:0] green_r;
  logic [CHAN_W-1:0] blue_r;

  function automatic logic [CHAN_W-1:0] scale(input logic [PRW-1:0] x);
    logic [PRW:0]              t;
    logic [PRW-2*FRACTION_BITS:0] y;
    t = (PRW + 1)'(x) + ((PRW + 1)'(1) << (2 * FRACTION_BITS - 1));
    y = (PRW - 2 * FRACTION_BITS + 1)'(t >> (2 * FRACTION_BITS));
    scale = (y > (PRW - 2 * FRACTION_BITS + 1)'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX)
                                                           : CHAN_W'(y);
  endfunction

  always_comb begin
    wp5_nxt = ONE - sat;
    wq5_nxt = ONE - sf;
    wt5_nxt = ONE - sat + sf;
    v5_nxt  = (VW'(val) << 8) - VW'(val);
  end

  always_comb begin
    cv = scale(pv6_r);
    cp = scale(pp6_r);
    cq = scale(pq6_r);
    ct = scale(pt6_r);
    case (sec6_r)
      SEC_RED_YELLOW: begin
        red_nxt = cv; green_nxt = ct; blue_nxt = cp;
      end
      SEC_YELLOW_GREEN: begin
        red_nxt = cq; green_nxt = cv; blue_nxt = cp;
      end
      SEC_GREEN_CYAN: begin
        red_nxt = cp; green_nxt = cv; blue_nxt = ct;
      end
      SEC_CYAN_BLUE: begin
        red_nxt = cp; green_nxt = cq; blue_nxt = cv;
      end
      SEC_BLUE_MAGENTA: begin
        red_nxt = ct; green_nxt = cp; blue_nxt = cv;
      end
      default: begin
        red_nxt = cv; green_nxt = cp; blue_nxt = cq;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sec5_r <= sector_i;
      wp5_r  <= wp5_nxt;
      wq5_r  <= wq5_nxt;
      wt5_r  <= wt5_nxt;
      v5_r   <= v5_nxt;
    end
    if (en[1]) begin
      sec6_r <= sec5_r;
      pv6_r  <= PRW'(v5_r) << FRACTION_BITS;
      pp6_r  <= PRW'(v5_r) * PRW'(wp5_r);
      pq6_r  <= PRW'(v5_r) * PRW'(wq5_r);
      pt6_r  <= PRW'(v5_r) * PRW'(wt5_r);
    end
    if (en[2]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

>>> hdl/hsv_to_rgb_converter.sv
// hsv to rgb pixel converter
// input channel: in_valid / in_stall with in_hue (1/2^HUE_FRACTION_BITS degree),
//   in_saturation and in_brightness (fractions, 2^FRACTION_BITS = 1.0)
// output channel: out_valid / out_stall with 8-bit out_red, out_green, out_blue
// a transfer happens on a rising edge where valid is high and stall is low
// seven register stages; a pixel taken at one edge moves through them to the
//   output register when nothing stalls
// throughput: one pixel per clock unless stalled, set by the seven-stage
//   pipeline with at most one multiplier level per stage (sector split, s*pos,
//   divide estimate, correction, weights, channel products, round and route)
// each stage has a valid bit; a stage loads when it is empty or the stage
//   after it moves, so bubbles close up behind a stalled output
// when the receiver stalls, the output register holds its pixel and the
//   pipeline keeps filling until every stage is full, then in_stall rises
// in_stall follows out_stall within the same cycle through the stage chain
// reset (rst_n low, synchronous) empties every stage; no pixel is lost or
//   repeated across stalls
module hsv_to_rgb_converter #(
  parameter int FRACTION_BITS     = 16,
  parameter int HUE_FRACTION_BITS = 6
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]          in_hue,
  input  logic [FRACTION_BITS:0]                 in_saturation,
  input  logic [FRACTION_BITS:0]                 in_brightness,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]         out_red,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]         out_green,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]         out_blue
);
  import hsv2rgb_pkg::*;

  localparam int SW     = FRACTION_BITS + 1;
  localparam int SECTOR = SECTOR_DEG << HUE_FRACTION_BITS;
  // position inside a sector is below the sector width
  localparam int POS_W  = $clog2(SECTOR);

  // per-stage valid bits and load enables
  logic [PIPE_DEPTH:1] vld_r;
  logic [PIPE_DEPTH:1] vld_nxt;
  logic [PIPE_DEPTH:1] adv;

  // stage 1 to stage 2
  sector_t          sec1;
  logic [POS_W-1:0] pos1;
  logic [SW-1:0]    sat1;
  logic [SW-1:0]    val1;

  // stage 4 to stage 5
  sector_t          sec4;
  logic [SW-1:0]    sat4;
  logic [SW-1:0]    sf4;
  logic [SW-1:0]    val4;

  // a stage loads when empty or when the next one moves on
  always_comb begin
    adv[PIPE_DEPTH] = !vld_r[PIPE_DEPTH] || !out_stall;
    for (int i = PIPE_DEPTH - 1; i >= 1; i--) begin
      adv[i] = !vld_r[i] || adv[i + 1];
    end
    vld_nxt[1] = adv[1] ? in_valid : vld_r[1];
    for (int i = 2; i <= PIPE_DEPTH; i++) begin
      vld_nxt[i] = adv[i] ? vld_r[i - 1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !adv[1];
  assign out_valid = vld_r[PIPE_DEPTH];

  // hue wrap, sector and position, saturation clamp
  hsv2rgb_split #(
    .FRACTION_BITS     (FRACTION_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
    .SW                (SW),
    .POS_W             (POS_W)
  ) u_split (
    .clk    (clk),
    .en     (adv[1]),
    .hue    (in_hue),
    .sat    (in_saturation),
    .val    (in_brightness),
    .sector (sec1),
    .pos    (pos1),
    .sat_c  (sat1),
    .val_o  (val1)
  );

  // rounded s * f through multiply and divide by the sector width
  hsv2rgb_frac #(
    .FRACTION_BITS     (FRACTION_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
    .SW                (SW),
    .POS_W             (POS_W)
  ) u_frac (
    .clk      (clk),
    .en       (adv[4:2]),
    .sector_i (sec1),
    .pos      (pos1),
    .sat_i    (sat1),
    .val_i    (val1),
    .sector_o (sec4),
    .sat_o    (sat4),
    .sf_o     (sf4),
    .val_o    (val4)
  );

  // p, q, t weights, channel scaling and routing, output register
  hsv2rgb_mix #(
    .FRACTION_BITS (FRACTION_BITS),
    .SW            (SW)
  ) u_mix (
    .clk      (clk),
    .en       (adv[7:5]),
    .sector_i (sec4),
    .sat      (sat4),
    .sf       (sf4),
    .val      (val4),
    .red      (out_red),
    .green    (out_green),
    .blue     (out_blue)
  );

`ifndef NO_ASSERTIONS
  // a free output means the whole chain can move, so input is never held
  a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // an accepted pixel always lands in the first stage
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[1])
    else $error("accepted pixel lost at first stage");

  // a new result only comes from a pixel in the stage before
  a_out_from_s6: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(vld_r[PIPE_DEPTH - 1]))
    else $error("output valid without a pixel behind it");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("pipeline not empty after reset");
`endif

endmodule
